>>> src/assert_macros.svh
// Assertion macros shared by the slot free list RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define LFL_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed");
`define LFL_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define LFL_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define LFL_ASSERT_ALWAYS(lbl, expr)
`define LFL_ASSERT_IMPLY(lbl, ante, cons)
`define LFL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> src/lfl_pkg.sv
// Constants, codes and types of the looped slot free list.
package lfl_pkg;
   localparam int ENTRIES    = 64;
   localparam int SLOT_W     = $clog2(ENTRIES);
   localparam int CNT_W      = $clog2(ENTRIES + 1);
   localparam int SLOT_OUT_W = 7;
   localparam int OP_W       = 2;
   localparam int SND_W      = 16;
   localparam int CH_W       = 8;
   localparam int OWN_W      = 12;
   localparam int KEY_W      = OWN_W;

   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_STOP   = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_NONE = 1'b1;

   localparam logic [CH_W-1:0]       NO_CHANNEL = '1;
   localparam logic [SLOT_OUT_W-1:0] NO_SLOT    = SLOT_OUT_W'(ENTRIES);

   typedef struct packed {
      logic                  valid;
      logic                  status;
      logic [SLOT_OUT_W-1:0] slot;
      logic [CH_W-1:0]       stop_channel;
      logic                  last;
   } emit_type;
endpackage

>>> src/lfl_ifs.sv
// Request and response channel interfaces.
interface lfl_req_if;
   import lfl_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [OP_W-1:0]        op;
   logic [SND_W-1:0]       sound_id;
   logic signed [CH_W-1:0] channel;
   logic [OWN_W-1:0]       owner;
   logic                   owner_in_game;
   logic                   owner_allocated;
   modport source (output valid, op, sound_id, channel, owner, owner_in_game,
                   owner_allocated, input ready);
   modport sink (input valid, op, sound_id, channel, owner, owner_in_game,
                 owner_allocated, output ready);
endinterface

interface lfl_rsp_if;
   import lfl_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   status;
   logic [SLOT_OUT_W-1:0]  slot;
   logic signed [CH_W-1:0] stop_channel;
   logic                   last;
   modport source (output valid, status, slot, stop_channel, last, input ready);
   modport sink (input valid, status, slot, stop_channel, last, output ready);
endinterface

>>> src/lfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

>>> src/lfl_seq.sv
// Sequencer: slot table, free stack and used list walked with one shared comparator.
`include "assert_macros.svh"
module lfl_seq (
   input  logic              clock,
   input  logic              reset,
   lfl_req_if.sink           req_chan,
   input  logic              out_free,
   output lfl_pkg::emit_type emit
);
   import lfl_pkg::*;

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_ADD_WR     = 4'd1;
   localparam logic [3:0] S_SCAN_ISSUE = 4'd2;
   localparam logic [3:0] S_SCAN_SLOT  = 4'd3;
   localparam logic [3:0] S_SCAN_CMP   = 4'd4;
   localparam logic [3:0] S_FREE_WR    = 4'd5;
   localparam logic [3:0] S_DONE       = 4'd6;
   localparam logic [3:0] S_CLR_RD     = 4'd7;
   localparam logic [3:0] S_CLR_CHK    = 4'd8;

   logic [3:0]         state_ff, state_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [ENTRIES-1:0] active_ff, active_in;
   logic [ENTRIES-1:0] fvalid_ff, fvalid_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0]  pend_slot_ff, pend_slot_in;
   logic [CH_W-1:0]    pend_ch_ff, pend_ch_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [CH_W-1:0]    key_ch_ff, key_ch_in;
   logic [OWN_W-1:0]   key_own_ff, key_own_in;
   logic [SLOT_W-1:0]  hit_slot_ff, hit_slot_in;
   logic [CH_W-1:0]    hit_ch_ff, hit_ch_in;

   logic                    used_we, free_we, slot_we;
   logic [SLOT_W-1:0]       used_waddr, used_raddr, used_wdata, used_rdata;
   logic [SLOT_W-1:0]       free_waddr, free_raddr, free_wdata, free_rdata;
   logic [SLOT_W-1:0]       slot_waddr, slot_raddr;
   logic [CH_W+OWN_W-1:0]   slot_wdata, slot_rdata;

   logic              accept, reject_add, match;
   logic [CNT_W-1:0]  nidx, top_cnt, pop_cnt, push_cnt;
   logic [SLOT_W-1:0] idx_slot, top_pos, pop_pos, push_pos, pop_slot;
   logic [CH_W-1:0]   slot_ch_rd;
   logic [OWN_W-1:0]  slot_own_rd;
   logic [KEY_W-1:0]  cmp_a, cmp_b;

   lfl_ram #(.WIDTH(SLOT_W), .DEPTH(ENTRIES)) u_used_ram (
      .clock(clock), .we(used_we), .waddr(used_waddr), .wdata(used_wdata),
      .raddr(used_raddr), .rdata(used_rdata));

   lfl_ram #(.WIDTH(SLOT_W), .DEPTH(ENTRIES)) u_free_ram (
      .clock(clock), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
      .raddr(free_raddr), .rdata(free_rdata));

   lfl_ram #(.WIDTH(CH_W + OWN_W), .DEPTH(ENTRIES)) u_slot_ram (
      .clock(clock), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
      .raddr(slot_raddr), .rdata(slot_rdata));

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   assign nidx     = idx_ff + CNT_W'(1);
   assign idx_slot = idx_ff[SLOT_W-1:0];
   assign top_cnt  = cnt_ff - CNT_W'(1);
   assign top_pos  = top_cnt[SLOT_W-1:0];
   assign pop_cnt  = CNT_W'(ENTRIES - 1) - cnt_ff;
   assign pop_pos  = pop_cnt[SLOT_W-1:0];
   assign push_cnt = CNT_W'(ENTRIES) - cnt_ff;
   assign push_pos = push_cnt[SLOT_W-1:0];
   // untouched free stack entries hold their own position
   assign pop_slot = fvalid_ff[pop_pos] ? free_rdata : pop_pos;

   assign slot_ch_rd  = slot_rdata[CH_W+OWN_W-1:OWN_W];
   assign slot_own_rd = slot_rdata[OWN_W-1:0];

   // shared key comparator: channel for remove, owner for stop
   assign cmp_a = (op_ff == OP_REMOVE) ? KEY_W'(slot_ch_rd) : slot_own_rd;
   assign cmp_b = (op_ff == OP_REMOVE) ? KEY_W'(key_ch_ff) : key_own_ff;
   assign match = (cmp_a == cmp_b);

   assign reject_add = (req_chan.sound_id == '0) || (req_chan.channel == NO_CHANNEL) ||
                       !req_chan.owner_in_game || (cnt_ff == CNT_W'(ENTRIES));

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      active_in     = active_ff;
      fvalid_in     = fvalid_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_ch_in    = pend_ch_ff;
      op_in         = op_ff;
      key_ch_in     = key_ch_ff;
      key_own_in    = key_own_ff;
      hit_slot_in   = hit_slot_ff;
      hit_ch_in     = hit_ch_ff;
      used_we       = 1'b0;
      used_waddr    = idx_slot;
      used_wdata    = used_rdata;
      used_raddr    = top_pos;
      free_we       = 1'b0;
      free_waddr    = push_pos;
      free_wdata    = hit_slot_ff;
      free_raddr    = pop_pos;
      slot_we       = 1'b0;
      slot_waddr    = pop_slot;
      slot_wdata    = {key_ch_ff, key_own_ff};
      slot_raddr    = used_rdata;
      emit          = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in         = req_chan.op;
               key_ch_in     = req_chan.channel;
               key_own_in    = req_chan.owner;
               idx_in        = '0;
               pend_valid_in = 1'b0;
               unique case (req_chan.op)
                  OP_ADD:    state_in = reject_add ? S_DONE : S_ADD_WR;
                  OP_REMOVE: state_in = S_SCAN_ISSUE;
                  OP_STOP:   state_in = req_chan.owner_allocated ? S_SCAN_ISSUE : S_DONE;
                  OP_CLEAR:  state_in = S_CLR_RD;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_ADD_WR: begin
            if (out_free) begin
               used_we              = 1'b1;
               used_waddr           = cnt_ff[SLOT_W-1:0];
               used_wdata           = pop_slot;
               slot_we              = 1'b1;
               active_in[pop_slot]  = 1'b1;
               cnt_in               = cnt_ff + CNT_W'(1);
               emit = '{valid: 1'b1, status: STATUS_OK, slot: SLOT_OUT_W'(pop_slot),
                        stop_channel: NO_CHANNEL, last: 1'b1};
               state_in = S_IDLE;
            end
         end
         S_SCAN_ISSUE: begin
            used_raddr = idx_slot;
            state_in   = (idx_ff == cnt_ff) ? S_DONE : S_SCAN_SLOT;
         end
         S_SCAN_SLOT: begin
            hit_slot_in = used_rdata;
            state_in    = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (match) begin
               hit_ch_in = slot_ch_rd;
               state_in  = S_FREE_WR;
            end else begin
               idx_in     = nidx;
               used_raddr = nidx[SLOT_W-1:0];
               state_in   = (nidx == cnt_ff) ? S_DONE : S_SCAN_SLOT;
            end
         end
         S_FREE_WR: begin
            // used_rdata holds the last list entry; it moves into the hole
            if (out_free || (op_ff == OP_STOP && !pend_valid_ff)) begin
               used_we                = 1'b1;
               free_we                = 1'b1;
               fvalid_in[push_pos]    = 1'b1;
               active_in[hit_slot_ff] = 1'b0;
               cnt_in                 = top_cnt;
               if (op_ff == OP_REMOVE) begin
                  emit = '{valid: 1'b1, status: STATUS_OK,
                           slot: SLOT_OUT_W'(hit_slot_ff),
                           stop_channel: NO_CHANNEL, last: 1'b1};
                  state_in = S_IDLE;
               end else begin
                  emit = '{valid: pend_valid_ff, status: STATUS_OK,
                           slot: SLOT_OUT_W'(pend_slot_ff),
                           stop_channel: pend_ch_ff, last: 1'b0};
                  pend_valid_in = 1'b1;
                  pend_slot_in  = hit_slot_ff;
                  pend_ch_in    = hit_ch_ff;
                  idx_in        = '0;
                  state_in      = S_SCAN_ISSUE;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               if (pend_valid_ff) begin
                  emit = '{valid: 1'b1, status: STATUS_OK,
                           slot: SLOT_OUT_W'(pend_slot_ff),
                           stop_channel: pend_ch_ff, last: 1'b1};
               end else begin
                  emit = '{valid: 1'b1, status: STATUS_NONE, slot: NO_SLOT,
                           stop_channel: NO_CHANNEL, last: 1'b1};
               end
               if (op_ff == OP_CLEAR) begin
                  cnt_in    = '0;
                  active_in = '0;
                  fvalid_in = '0;
               end
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         S_CLR_RD: begin
            slot_raddr = idx_slot;
            state_in   = S_CLR_CHK;
         end
         S_CLR_CHK: begin
            slot_raddr = idx_slot;
            if (!active_ff[idx_slot] || !pend_valid_ff || out_free) begin
               if (active_ff[idx_slot]) begin
                  emit = '{valid: pend_valid_ff, status: STATUS_OK,
                           slot: SLOT_OUT_W'(pend_slot_ff),
                           stop_channel: pend_ch_ff, last: 1'b0};
                  pend_valid_in = 1'b1;
                  pend_slot_in  = idx_slot;
                  pend_ch_in    = slot_ch_rd;
               end
               if (idx_ff == CNT_W'(ENTRIES - 1)) begin
                  state_in = S_DONE;
               end else begin
                  idx_in   = nidx;
                  state_in = S_CLR_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         idx_ff        <= '0;
         cnt_ff        <= '0;
         active_ff     <= '0;
         fvalid_ff     <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         cnt_ff        <= cnt_in;
         active_ff     <= active_in;
         fvalid_ff     <= fvalid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_slot_ff <= pend_slot_in;
      pend_ch_ff   <= pend_ch_in;
      op_ff        <= op_in;
      key_ch_ff    <= key_ch_in;
      key_own_ff   <= key_own_in;
      hit_slot_ff  <= hit_slot_in;
      hit_ch_ff    <= hit_ch_in;
   end

   `LFL_ASSERT_ALWAYS(a_cnt_bound, cnt_ff <= CNT_W'(ENTRIES))
   `LFL_ASSERT_ALWAYS(a_active_matches_cnt, $countones(active_ff) == int'(cnt_ff))
   `LFL_ASSERT_IMPLY(a_emit_has_room, emit.valid, out_free)
   `LFL_ASSERT_NEXT(a_busy_after_accept, accept, state_ff != S_IDLE)
endmodule

>>> src/looped_slot_free_list_core.sv
// Top level of the looped slot free list: sequencer plus response register.
//
//   port      role    word
//   req_chan  sink    op, sound_id, channel, owner, owner_in_game, owner_allocated
//   rsp_chan  source  status, slot, stop_channel, last
//
// Remove: one comparator walks the used list, reading the used-list RAM and then
// the slot RAM for each entry. Stop: the walk restarts at the list head after
// each freed slot. Clear: every one of the ENTRIES slots is visited.
// Synchronous reset; table state comes back through valid bits, no clear pass.
// One word at a time; the sequencer waits while the response register is full.
module looped_slot_free_list_core (
   input logic       clock,
   input logic       reset,
   lfl_req_if.sink   req_chan,
   lfl_rsp_if.source rsp_chan
);
   import lfl_pkg::*;

   emit_type emit;
   logic     out_free;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  status_ff;
   logic [SLOT_OUT_W-1:0] slot_ff;
   logic [CH_W-1:0]       stop_channel_ff;
   logic                  last_ff;

   lfl_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .out_free (out_free),
      .emit     (emit)
   );

   assign out_free     = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_valid_in = emit.valid || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid) begin
         status_ff       <= emit.status;
         slot_ff         <= emit.slot;
         stop_channel_ff <= emit.stop_channel;
         last_ff         <= emit.last;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.slot         = slot_ff;
   assign rsp_chan.stop_channel = stop_channel_ff;
   assign rsp_chan.last         = last_ff;
endmodule

>>> tb/looped_slot_free_list_core_tb.sv
// Testbench for the looped slot free list: directed and random traffic, predicted.
`timescale 1ns / 1ps

module looped_slot_free_list_core_tb;
   import lfl_pkg::*;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [SND_W-1:0] sound_id;
      logic [CH_W-1:0]  channel;
      logic [OWN_W-1:0] owner;
      logic             in_game;
      logic             allocated;
   } table_req_type;

   typedef struct packed {
      logic                  status;
      logic [SLOT_OUT_W-1:0] slot;
      logic [CH_W-1:0]       stop_channel;
      logic                  last;
   } slot_report_type;

   logic clock = 1'b0;
   logic reset;

   lfl_req_if req_chan ();
   lfl_rsp_if rsp_chan ();

   looped_slot_free_list_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   // predicted slot table
   logic [CH_W-1:0]       tbl_channel [ENTRIES];
   logic [SND_W-1:0]      tbl_sound   [ENTRIES];
   logic [OWN_W-1:0]      tbl_owner   [ENTRIES];
   logic [SLOT_OUT_W-1:0] free_slots  [ENTRIES];
   logic [SLOT_OUT_W-1:0] used_slots  [ENTRIES];
   int                    used_n;

   slot_report_type reports_due [$];
   int              mismatches = 0;
   bit              calm = 1'b0;

   function automatic void table_reset();
      for (int i = 0; i < ENTRIES; i++) begin
         tbl_channel[i] = NO_CHANNEL;
         tbl_sound[i]   = '0;
         tbl_owner[i]   = '1;
         free_slots[i]  = SLOT_OUT_W'(i);
         used_slots[i]  = NO_SLOT;
      end
      used_n = 0;
   endfunction

   function automatic void queue_report(logic st, logic [SLOT_OUT_W-1:0] sl,
                                        logic [CH_W-1:0] ch, logic lst);
      slot_report_type r;
      r.status       = st;
      r.slot         = sl;
      r.stop_channel = ch;
      r.last         = lst;
      reports_due.push_back(r);
   endfunction

   // swap-with-last removal from the used list, slot goes back on the free stack
   function automatic logic [SLOT_OUT_W-1:0] release_at(int pos);
      logic [SLOT_OUT_W-1:0] s;
      int top;
      s = used_slots[pos];
      top = used_n - 1;
      used_slots[pos] = used_slots[top];
      used_slots[top] = NO_SLOT;
      used_n = top;
      free_slots[ENTRIES - used_n - 1] = s;
      if (s < ENTRIES) begin
         tbl_channel[s] = NO_CHANNEL;
         tbl_sound[s]   = '0;
         tbl_owner[s]   = '1;
      end
      return s;
   endfunction

   function automatic void apply_table_op(table_req_type w);
      logic [SLOT_OUT_W-1:0] s;
      logic [CH_W-1:0]       c;
      int                    n;
      int                    i;
      bit                    hit;
      n = 0;
      case (w.op)
         OP_ADD: begin
            if (w.sound_id == '0 || w.channel == NO_CHANNEL || !w.in_game ||
                used_n >= ENTRIES) begin
               queue_report(STATUS_NONE, NO_SLOT, NO_CHANNEL, 1'b1);
            end else begin
               s = free_slots[ENTRIES - used_n - 1];
               if (s >= ENTRIES) begin
                  queue_report(STATUS_NONE, NO_SLOT, NO_CHANNEL, 1'b1);
               end else begin
                  used_slots[used_n] = s;
                  used_n++;
                  tbl_channel[s] = w.channel;
                  tbl_sound[s]   = w.sound_id;
                  tbl_owner[s]   = w.owner;
                  queue_report(STATUS_OK, s, NO_CHANNEL, 1'b1);
               end
            end
         end
         OP_REMOVE: begin
            hit = 1'b0;
            for (i = 0; i < used_n && !hit; i++) begin
               if (used_slots[i] < ENTRIES && tbl_channel[used_slots[i]] == w.channel) begin
                  s = release_at(i);
                  queue_report(STATUS_OK, s, NO_CHANNEL, 1'b1);
                  hit = 1'b1;
               end
            end
            if (!hit) queue_report(STATUS_NONE, NO_SLOT, NO_CHANNEL, 1'b1);
         end
         OP_STOP: begin
            if (!w.allocated) begin
               queue_report(STATUS_NONE, NO_SLOT, NO_CHANNEL, 1'b1);
            end else begin
               hit = 1'b1;
               // rescan from the list head after every freed slot
               while (hit && used_n > 0) begin
                  hit = 1'b0;
                  for (i = 0; i < used_n && !hit; i++) begin
                     if (used_slots[i] < ENTRIES && tbl_owner[used_slots[i]] == w.owner) begin
                        c = tbl_channel[used_slots[i]];
                        s = release_at(i);
                        queue_report(STATUS_OK, s, c, 1'b0);
                        n++;
                        hit = 1'b1;
                     end
                  end
               end
               if (n == 0) queue_report(STATUS_NONE, NO_SLOT, NO_CHANNEL, 1'b1);
               else reports_due[reports_due.size() - 1].last = 1'b1;
            end
         end
         default: begin
            for (i = 0; i < ENTRIES; i++) begin
               if (tbl_channel[i] != NO_CHANNEL) begin
                  queue_report(STATUS_OK, SLOT_OUT_W'(i), tbl_channel[i], 1'b0);
                  n++;
               end
            end
            table_reset();
            if (n == 0) queue_report(STATUS_NONE, NO_SLOT, NO_CHANNEL, 1'b1);
            else reports_due[reports_due.size() - 1].last = 1'b1;
         end
      endcase
   endfunction

   function automatic table_req_type mk(logic [OP_W-1:0] op, logic [SND_W-1:0] snd,
                                        logic [CH_W-1:0] ch, logic [OWN_W-1:0] own,
                                        logic ig, logic al);
      table_req_type w;
      w.op        = op;
      w.sound_id  = snd;
      w.channel   = ch;
      w.owner     = own;
      w.in_game   = ig;
      w.allocated = al;
      return w;
   endfunction

   // random word, biased so removes and stops mostly hit live entries
   function automatic table_req_type pick_req(int add_pct);
      table_req_type w;
      int roll;
      int kind;
      logic [SLOT_OUT_W-1:0] s;
      roll = $urandom_range(0, 99);
      kind = $urandom_range(0, 99);
      w.sound_id  = ($urandom_range(0, 19) == 0) ? '0 : SND_W'($urandom);
      w.channel   = ($urandom_range(0, 3) == 0) ? CH_W'($urandom) : CH_W'($urandom_range(0, 11));
      w.owner     = ($urandom_range(0, 9) == 0) ? OWN_W'($urandom) : OWN_W'($urandom_range(0, 5));
      w.in_game   = ($urandom_range(0, 9) != 0);
      w.allocated = ($urandom_range(0, 9) != 0);
      if (roll < add_pct) begin
         w.op = OP_ADD;
      end else if (kind < 60) begin
         w.op = OP_REMOVE;
         if (used_n > 0 && $urandom_range(0, 9) < 7) begin
            s = used_slots[$urandom_range(0, used_n - 1)];
            w.channel = tbl_channel[s];
         end
      end else if (kind < 93) begin
         w.op = OP_STOP;
         if (used_n > 0 && $urandom_range(0, 9) < 7) begin
            s = used_slots[$urandom_range(0, used_n - 1)];
            w.owner = tbl_owner[s];
         end
      end else begin
         w.op = OP_CLEAR;
      end
      return w;
   endfunction

   task automatic send_word(table_req_type w);
      if (!calm && $urandom_range(0, 99) < 16) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_chan.valid           <= 1'b1;
      req_chan.op              <= w.op;
      req_chan.sound_id        <= w.sound_id;
      req_chan.channel         <= w.channel;
      req_chan.owner           <= w.owner;
      req_chan.owner_in_game   <= w.in_game;
      req_chan.owner_allocated <= w.allocated;
      do @(posedge clock); while (!req_chan.ready);
      apply_table_op(w);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (reports_due.size() != 0);
   endtask

   task automatic test_rejects_on_empty();
      send_word(mk(OP_REMOVE, 16'd9, 8'd3, 12'd1, 1'b1, 1'b1));
      send_word(mk(OP_STOP, 16'd9, 8'd3, 12'd1, 1'b1, 1'b1));
      send_word(mk(OP_CLEAR, 16'd9, 8'd3, 12'd1, 1'b1, 1'b1));
      send_word(mk(OP_ADD, 16'd0, 8'd5, 12'd1, 1'b1, 1'b1));
      send_word(mk(OP_ADD, 16'd1, NO_CHANNEL, 12'd1, 1'b1, 1'b1));
      send_word(mk(OP_ADD, 16'd1, 8'd5, 12'd1, 1'b0, 1'b1));
   endtask

   task automatic test_field_extremes();
      send_word(mk(OP_ADD, 16'hFFFF, 8'h7F, 12'hFFF, 1'b1, 1'b0));
      send_word(mk(OP_ADD, 16'h0001, 8'h00, 12'h000, 1'b1, 1'b1));
      send_word(mk(OP_ADD, 16'h8000, 8'h80, 12'h800, 1'b1, 1'b1));
      send_word(mk(OP_ADD, 16'h1234, 8'hFE, 12'hFFF, 1'b1, 1'b1));
   endtask

   task automatic test_remove_by_channel();
      send_word(mk(OP_REMOVE, 16'd0, NO_CHANNEL, 12'd0, 1'b0, 1'b0));
      send_word(mk(OP_REMOVE, 16'd0, 8'h80, 12'd0, 1'b0, 1'b0));
      send_word(mk(OP_REMOVE, 16'd0, 8'd99, 12'd0, 1'b0, 1'b0));
      send_word(mk(OP_REMOVE, 16'd0, 8'h7F, 12'd0, 1'b0, 1'b0));
   endtask

   task automatic test_stop_by_owner();
      send_word(mk(OP_ADD, 16'd7, 8'd10, 12'd9, 1'b1, 1'b1));
      send_word(mk(OP_ADD, 16'd8, 8'd11, 12'd9, 1'b1, 1'b1));
      send_word(mk(OP_ADD, 16'd9, 8'd12, 12'd3, 1'b1, 1'b1));
      send_word(mk(OP_STOP, 16'd0, 8'd0, 12'd9, 1'b1, 1'b0));
      send_word(mk(OP_STOP, 16'd0, 8'd0, 12'd9, 1'b0, 1'b1));
      send_word(mk(OP_STOP, 16'd0, 8'd0, 12'hFFF, 1'b1, 1'b1));
   endtask

   task automatic test_clear_report();
      send_word(mk(OP_ADD, 16'd21, 8'd40, 12'd4, 1'b1, 1'b1));
      send_word(mk(OP_ADD, 16'd22, 8'hC0, 12'd5, 1'b1, 1'b1));
      send_word(mk(OP_CLEAR, 16'd0, 8'd0, 12'd0, 1'b0, 1'b0));
   endtask

   // fill to capacity, overflow, then tear down by channel, owner and clear
   task automatic test_full_table();
      table_req_type w;
      for (int i = 0; i < ENTRIES; i++) begin
         w = mk(OP_ADD, SND_W'($urandom_range(1, 65535)), CH_W'($urandom_range(0, 127)),
                OWN_W'($urandom_range(1, 2)), 1'b1, 1'b1);
         send_word(w);
      end
      send_word(mk(OP_ADD, 16'd5, 8'd5, 12'd1, 1'b1, 1'b1));
      send_word(mk(OP_REMOVE, 16'd0, tbl_channel[used_slots[ENTRIES / 2]], 12'd0, 1'b1, 1'b1));
      send_word(mk(OP_STOP, 16'd0, 8'd0, 12'd1, 1'b1, 1'b1));
      send_word(mk(OP_CLEAR, 16'd0, 8'd0, 12'd0, 1'b1, 1'b1));
   endtask

   task automatic test_random_mix(int count, int add_pct);
      for (int i = 0; i < count; i++) begin
         send_word(pick_req(add_pct));
         if (i % 60 == 59) wait_drained();
      end
   endtask

   task automatic test_calm_stretch(int count);
      calm = 1'b1;
      test_random_mix(count, 60);
      calm = 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_chan.ready <= calm || ($urandom_range(0, 99) >= 16);
   end

   always @(posedge clock) begin
      slot_report_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (reports_due.size() == 0) begin
            $error("unexpected word: status %0d slot %0d stop_channel %0d last %0d",
                   rsp_chan.status, rsp_chan.slot, rsp_chan.stop_channel, rsp_chan.last);
            mismatches++;
         end else begin
            want = reports_due.pop_front();
            if (rsp_chan.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
               mismatches++;
            end
            if (rsp_chan.slot !== want.slot) begin
               $error("slot: expected %0d, got %0d", want.slot, rsp_chan.slot);
               mismatches++;
            end
            if (rsp_chan.stop_channel !== want.stop_channel) begin
               $error("stop_channel: expected %0d, got %0d",
                      $signed(want.stop_channel), rsp_chan.stop_channel);
               mismatches++;
            end
            if (rsp_chan.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_chan.last);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #60_000_000;
      $display("looped_slot_free_list_core_tb: errors");
      $finish;
   end

   initial begin
      table_reset();
      reset                    = 1'b1;
      req_chan.valid           = 1'b0;
      req_chan.op              = OP_ADD;
      req_chan.sound_id        = '0;
      req_chan.channel         = '0;
      req_chan.owner           = '0;
      req_chan.owner_in_game   = 1'b0;
      req_chan.owner_allocated = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_rejects_on_empty();
      test_field_extremes();
      test_remove_by_channel();
      test_stop_by_owner();
      test_clear_report();
      wait_drained();
      test_full_table();
      test_random_mix(150, 50);
      test_random_mix(100, 80);
      wait_drained();
      test_calm_stretch(60);
      req_chan.valid <= 1'b0;
      while (reports_due.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0) begin
         $display("looped_slot_free_list_core_tb: clean");
      end else begin
         $display("looped_slot_free_list_core_tb: errors");
      end
      $finish;
   end
endmodule
